/* rtl/core/rbba_pkg.sv */
// Shared types and constants for the round-based bank allocator.
// Holds widths, queue entry layout, status codes and the shared ALU interface.
// Depends on nothing; rbba_alu and the top level refer to it by scoped names.
package rbba_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 16;
  localparam int SIZE_W  = 21;
  localparam int ROUND_W = 16;
  localparam int ALU_W   = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(1048576);

  // Request actions on the action field
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_EVICT = 1'b1;

  typedef struct packed {
    logic [ROUND_W-1:0] round;
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_ALLOCATED  = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_EVICTED    = 3'd3,
    ST_NO_EVICT   = 3'd4,
    ST_QUEUE_FULL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD    = 2'd0,
    ALU_SUBSAT = 2'd1,
    ALU_LT     = 2'd2,
    ALU_EQ     = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             flag;
  } alu_rsp_t;

endpackage

/* rtl/core/rbba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the eviction queue entries; no dependencies.
module rbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/rbba_alu.sv */
// Shared add / saturating subtract / compare unit for the allocator sequencer.
// Depends on rbba_pkg for the request and response structs.
module rbba_alu (
  input  rbba_pkg::alu_req_t req,
  output rbba_pkg::alu_rsp_t rsp
);

  logic [rbba_pkg::ALU_W-1:0] sum;
  logic [rbba_pkg::ALU_W-1:0] diff;
  logic                       lt;

  assign sum  = req.a + req.b;
  assign diff = req.a - req.b;
  assign lt   = (req.a < req.b);

  always_comb begin
    rsp = '0;
    case (req.op)
      rbba_pkg::ALU_ADD: begin
        rsp.res = sum;
      end
      rbba_pkg::ALU_SUBSAT: begin
        rsp.res = lt ? '0 : diff;
      end
      rbba_pkg::ALU_LT: begin
        rsp.flag = lt;
      end
      rbba_pkg::ALU_EQ: begin
        rsp.flag = (req.a == req.b);
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

/* rtl/core/round_based_bank_allocator.sv */
// Round-based bank allocator: top level with the request sequencer.
// Uses rbba_pkg, rbba_alu (shared arithmetic/compare) and rbba_ram (queue store).
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in_     | in        | in_valid / in_stall   | action, tile_id, tile_size, round
//   out_    | out       | out_valid / out_stall | status, evicted_tile_id, usage
//   cfg_    | in        | cfg_we                | cfg_wdata -> bank capacity
//
// The queue RAM has a single read port: the id search walks the queue one entry
// at a time (S_SCAN_RD, then S_SCAN_CMP), and the compaction copies one entry at
// a time (S_SHIFT_RD, then S_SHIFT_WR).
// Reset (rst_n low, synchronous) empties the queue, zeroes usage and loads the
// capacity with its full-bank value. RAM contents are not cleared.
// in_stall is high whenever a request is in flight. A finished word waits in the
// output register under out_stall; a new request may be taken meanwhile, and its
// own result holds in the sequencer until the output register frees up.
module round_based_bank_allocator (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [rbba_pkg::ID_W-1:0]      in_tile_id,
  input  logic [rbba_pkg::SIZE_W-1:0]    in_tile_size,
  input  logic [rbba_pkg::ROUND_W-1:0]   in_round,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [rbba_pkg::ID_W-1:0]      out_evicted_tile_id,
  output logic [rbba_pkg::SIZE_W-1:0]    out_usage,

  input  logic                           cfg_we,
  input  logic [rbba_pkg::SIZE_W-1:0]    cfg_wdata
);

  // Sequencer states, one-hot.
  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_FIT      = 14'b00000000000010,
    S_SUM      = 14'b00000000000100,
    S_ROOM     = 14'b00000000001000,
    S_SCAN_RD  = 14'b00000000010000,
    S_SCAN_CMP = 14'b00000000100000,
    S_MERGE    = 14'b00000001000000,
    S_SHIFT_RD = 14'b00000010000000,
    S_SHIFT_WR = 14'b00000100000000,
    S_APPEND   = 14'b00001000000000,
    S_HEAD_RD  = 14'b00010000000000,
    S_HEAD_CMP = 14'b00100000000000,
    S_DRAIN    = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  localparam logic ACT_ALLOC = rbba_pkg::ACT_ALLOC;
  localparam logic [rbba_pkg::CNT_W-1:0] CNT_FULL = rbba_pkg::CNT_W'(rbba_pkg::QUEUE_DEPTH);
  localparam logic [rbba_pkg::CNT_W-1:0] CNT_ONE  = rbba_pkg::CNT_W'(1);

  state_t                          state_r, state_nxt;
  logic [rbba_pkg::SIZE_W-1:0]     cap_r;
  logic [rbba_pkg::SIZE_W-1:0]     usage_r, usage_nxt;
  logic [rbba_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [rbba_pkg::CNT_W-1:0]      idx_r, idx_nxt;
  logic                            found_r, found_nxt;
  logic                            act_r;
  logic [rbba_pkg::ID_W-1:0]       id_r;
  logic [rbba_pkg::SIZE_W-1:0]     size_r;
  logic [rbba_pkg::ROUND_W-1:0]    rnd_r;
  logic [rbba_pkg::ROUND_W-1:0]    tr_r, tr_nxt;
  logic [rbba_pkg::ALU_W-1:0]      tmp_r, tmp_nxt;
  rbba_pkg::status_t               status_r, status_nxt;
  logic [rbba_pkg::ID_W-1:0]       ev_id_r, ev_id_nxt;

  logic                            out_valid_r;
  rbba_pkg::status_t               out_status_r;
  logic [rbba_pkg::ID_W-1:0]       out_ev_id_r;
  logic [rbba_pkg::SIZE_W-1:0]     out_usage_r;

  rbba_pkg::alu_req_t              alu_req;
  rbba_pkg::alu_rsp_t              alu_rsp;

  logic                            ram_we;
  logic [rbba_pkg::IDX_W-1:0]      ram_waddr;
  rbba_pkg::entry_t                ram_wdata;
  logic [rbba_pkg::IDX_W-1:0]      ram_raddr;
  logic [rbba_pkg::ENTRY_W-1:0]    ram_rdata;
  rbba_pkg::entry_t                ent;

  logic                            in_take;
  logic                            out_load;
  logic [rbba_pkg::CNT_W:0]        idx_p1;
  logic [rbba_pkg::CNT_W:0]        idx_p2;
  logic [rbba_pkg::CNT_W:0]        cnt_x;
  logic [rbba_pkg::CNT_W-1:0]      app_pos;

  assign ent     = rbba_pkg::entry_t'(ram_rdata);
  assign in_take = in_valid && !in_stall;
  assign idx_p1  = {1'b0, idx_r} + (rbba_pkg::CNT_W + 1)'(1);
  assign idx_p2  = {1'b0, idx_r} + (rbba_pkg::CNT_W + 1)'(2);
  assign cnt_x   = {1'b0, count_r};
  // Re-queued tile reuses the tail slot; a new tile takes the next free one.
  assign app_pos = found_r ? (count_r - CNT_ONE) : count_r;

  rbba_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  rbba_ram #(
    .WIDTH (rbba_pkg::ENTRY_W),
    .DEPTH (rbba_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Read address: the next entry during compaction, else the walk index.
  assign ram_raddr = (state_r == S_SHIFT_RD) ? idx_p1[rbba_pkg::IDX_W-1:0]
                                             : idx_r[rbba_pkg::IDX_W-1:0];

  // Operand select for the shared unit.
  always_comb begin
    alu_req    = '0;
    alu_req.op = rbba_pkg::ALU_ADD;
    case (state_r)
      S_FIT: begin
        alu_req.op = rbba_pkg::ALU_LT;
        alu_req.a  = rbba_pkg::ALU_W'(cap_r);
        alu_req.b  = rbba_pkg::ALU_W'(size_r);
      end
      S_SUM: begin
        alu_req.op = rbba_pkg::ALU_ADD;
        alu_req.a  = rbba_pkg::ALU_W'(usage_r);
        alu_req.b  = rbba_pkg::ALU_W'(size_r);
      end
      S_ROOM: begin
        alu_req.op = rbba_pkg::ALU_LT;
        alu_req.a  = rbba_pkg::ALU_W'(cap_r);
        alu_req.b  = tmp_r;
      end
      S_SCAN_CMP: begin
        alu_req.op = rbba_pkg::ALU_EQ;
        alu_req.a  = rbba_pkg::ALU_W'(ent.id);
        alu_req.b  = rbba_pkg::ALU_W'(id_r);
      end
      S_MERGE: begin
        alu_req.op = rbba_pkg::ALU_LT;
        alu_req.a  = rbba_pkg::ALU_W'(rnd_r);
        alu_req.b  = rbba_pkg::ALU_W'(ent.round);
      end
      S_HEAD_CMP: begin
        alu_req.op = rbba_pkg::ALU_LT;
        alu_req.a  = rbba_pkg::ALU_W'(ent.round);
        alu_req.b  = rbba_pkg::ALU_W'(rnd_r);
      end
      S_DRAIN: begin
        alu_req.op = rbba_pkg::ALU_SUBSAT;
        alu_req.a  = rbba_pkg::ALU_W'(usage_r);
        alu_req.b  = rbba_pkg::ALU_W'(ent.size);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    usage_nxt  = usage_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    tr_nxt     = tr_r;
    tmp_nxt    = tmp_r;
    status_nxt = status_r;
    ev_id_nxt  = ev_id_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[rbba_pkg::IDX_W-1:0];
    ram_wdata  = ent;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          ev_id_nxt = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (in_action == ACT_ALLOC) begin
            state_nxt = S_FIT;
          end else if (count_r == '0) begin
            status_nxt = rbba_pkg::ST_NO_EVICT;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_HEAD_RD;
          end
        end
      end
      S_FIT: begin
        if (alu_rsp.flag) begin
          status_nxt = rbba_pkg::ST_TOO_LARGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        tmp_nxt   = alu_rsp.res;
        state_nxt = S_ROOM;
      end
      S_ROOM: begin
        tr_nxt = rnd_r;
        if (alu_rsp.flag) begin
          status_nxt = rbba_pkg::ST_NO_SPACE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        // End of queue without a match: append, or refuse if full.
        if (idx_r == count_r) begin
          if (count_r == CNT_FULL) begin
            status_nxt = rbba_pkg::ST_QUEUE_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (alu_rsp.flag) begin
          found_nxt = 1'b1;
          state_nxt = S_MERGE;
        end else begin
          idx_nxt   = idx_p1[rbba_pkg::CNT_W-1:0];
          state_nxt = S_SCAN_RD;
        end
      end
      S_MERGE: begin
        // Keep the later of the queued and requested rounds.
        if (alu_rsp.flag) begin
          tr_nxt = ent.round;
        end
        state_nxt = (idx_p1 < cnt_x) ? S_SHIFT_RD : S_APPEND;
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[rbba_pkg::IDX_W-1:0];
        ram_wdata = ent;
        idx_nxt   = idx_p1[rbba_pkg::CNT_W-1:0];
        if (idx_p2 < cnt_x) begin
          state_nxt = S_SHIFT_RD;
        end else if (act_r == ACT_ALLOC) begin
          state_nxt = S_APPEND;
        end else begin
          count_nxt = count_r - CNT_ONE;
          state_nxt = S_DONE;
        end
      end
      S_APPEND: begin
        ram_we          = 1'b1;
        ram_waddr       = app_pos[rbba_pkg::IDX_W-1:0];
        ram_wdata.round = tr_r;
        ram_wdata.id    = id_r;
        ram_wdata.size  = size_r;
        if (!found_r) begin
          count_nxt = count_r + CNT_ONE;
        end
        usage_nxt  = tmp_r[rbba_pkg::SIZE_W-1:0];
        status_nxt = rbba_pkg::ST_ALLOCATED;
        state_nxt  = S_DONE;
      end
      S_HEAD_RD: begin
        state_nxt = S_HEAD_CMP;
      end
      S_HEAD_CMP: begin
        if (alu_rsp.flag) begin
          ev_id_nxt = ent.id;
          state_nxt = S_DRAIN;
        end else begin
          status_nxt = rbba_pkg::ST_NO_EVICT;
          state_nxt  = S_DONE;
        end
      end
      S_DRAIN: begin
        usage_nxt  = alu_rsp.res[rbba_pkg::SIZE_W-1:0];
        status_nxt = rbba_pkg::ST_EVICTED;
        if (CNT_ONE < count_r) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          count_nxt = count_r - CNT_ONE;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= rbba_pkg::CAP_RESET;
      usage_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      usage_r <= usage_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r  <= in_action;
      id_r   <= in_tile_id;
      size_r <= in_tile_size;
      rnd_r  <= in_round;
    end
    tr_r     <= tr_nxt;
    tmp_r    <= tmp_nxt;
    status_r <= status_nxt;
    ev_id_r  <= ev_id_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_ev_id_r  <= ev_id_r;
      out_usage_r  <= usage_r;
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_evicted_tile_id = out_ev_id_r;
  assign out_usage           = out_usage_r;

endmodule

/* test/round_based_bank_allocator_tb.sv */
// Self-checking testbench for round_based_bank_allocator: directed and random
// allocate/evict words, capacity rewrites between batches, random stalls on both sides.
// Depends on rbba_pkg and the round_based_bank_allocator RTL only.
module round_based_bank_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W    = rbba_pkg::ID_W;
  localparam int SIZE_W  = rbba_pkg::SIZE_W;
  localparam int ROUND_W = rbba_pkg::ROUND_W;

  // Request opcodes on in_action
  localparam logic ACT_ALLOC = rbba_pkg::ACT_ALLOC;
  localparam logic ACT_EVICT = rbba_pkg::ACT_EVICT;

  localparam logic [SIZE_W-1:0] FULL_BANK = 21'd1048576;
  localparam int IDLE_PCT   = 24;
  localparam int BATCHES    = 20;
  localparam int BATCH_LEN  = 54;
  localparam int POOL_SPAN  = 24;   // more ids than queue slots, so the queue can fill
  localparam int MAX_SHOWN  = 10;
  localparam int DRAIN_WAIT = 40;   // wait for the slowest request with a full queue

  typedef struct {
    logic               action;
    logic [ID_W-1:0]    tile_id;
    logic [SIZE_W-1:0]  tile_size;
    logic [ROUND_W-1:0] round;
  } tile_request_t;

  typedef struct {
    rbba_pkg::status_t  status;
    logic [ID_W-1:0]    evicted_id;
    logic [SIZE_W-1:0]  usage;
  } bank_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid     = 1'b0;
  logic               in_action    = 1'b0;
  logic [ID_W-1:0]    in_tile_id   = '0;
  logic [SIZE_W-1:0]  in_tile_size = '0;
  logic [ROUND_W-1:0] in_round     = '0;
  logic               out_stall    = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [SIZE_W-1:0]  cfg_wdata    = '0;

  wire                in_stall;
  wire                out_valid;
  wire [2:0]          out_status;
  wire [ID_W-1:0]     out_evicted_tile_id;
  wire [SIZE_W-1:0]   out_usage;

  always #2 clk = ~clk;

  round_based_bank_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_tile_id          (in_tile_id),
    .in_tile_size        (in_tile_size),
    .in_round            (in_round),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_evicted_tile_id (out_evicted_tile_id),
    .out_usage           (out_usage),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  tile_request_t     pending_requests[$];   // words not yet taken by the block
  bank_result_t      expected_results[$];   // predicted words, oldest first
  rbba_pkg::entry_t  evict_order[$];        // predicted eviction queue, head first
  logic [SIZE_W-1:0] cap_units   = FULL_BANK;
  logic [SIZE_W-1:0] usage_units = '0;

  logic word_taken = 1'b0;  // input word accepted at the last rising edge
  logic calm       = 1'b0;  // suppress all idling on both sides
  int   round_base = 0;
  int   pool_base  = 0;
  int   errors     = 0;
  int   requests_taken = 0;
  int   results_seen   = 0;
  int   status_tally[6];

  // ---------------------------------------------------------------------------
  // Occupancy predictor: apply one request to the tracked bank state and
  // return the word the block must produce for it.
  // ---------------------------------------------------------------------------
  function automatic bank_result_t bank_occupancy_step(tile_request_t req);
    bank_result_t       res;
    rbba_pkg::entry_t   head;
    rbba_pkg::entry_t   fresh;
    logic [ROUND_W-1:0] keep_round;
    int                 hit;
    res.evicted_id = '0;
    if (req.action == ACT_ALLOC) begin
      hit = -1;
      foreach (evict_order[i]) begin
        if (hit < 0 && evict_order[i].id == req.tile_id) hit = i;
      end
      if (req.tile_size > cap_units) begin
        res.status = rbba_pkg::ST_TOO_LARGE;
      end else if ({1'b0, usage_units} + {1'b0, req.tile_size} > {1'b0, cap_units}) begin
        // also hit when the capacity was lowered under the current usage
        res.status = rbba_pkg::ST_NO_SPACE;
      end else if (hit < 0 && evict_order.size() >= rbba_pkg::QUEUE_DEPTH) begin
        res.status = rbba_pkg::ST_QUEUE_FULL;
      end else begin
        // a queued id moves to the tail, keeps the later round, takes the new size
        keep_round = req.round;
        if (hit >= 0) begin
          if (evict_order[hit].round > keep_round) keep_round = evict_order[hit].round;
          evict_order.delete(hit);
        end
        fresh = '{round: keep_round, id: req.tile_id, size: req.tile_size};
        evict_order.insert(evict_order.size(), fresh);
        usage_units = usage_units + req.tile_size;
        res.status  = rbba_pkg::ST_ALLOCATED;
      end
    end else if (evict_order.size() == 0 || evict_order[0].round >= req.round) begin
      res.status = rbba_pkg::ST_NO_EVICT;
    end else begin
      head           = evict_order[0];
      evict_order.delete(0);
      res.evicted_id = head.id;
      usage_units    = (head.size > usage_units) ? '0 : usage_units - head.size;
      res.status     = rbba_pkg::ST_EVICTED;
    end
    res.usage = usage_units;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels and the config port at the rising edge.
  // Check the result word first, then predict for a newly taken request, so
  // a request and an older result meeting on one edge stay in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sample_ports
    tile_request_t taken;
    bank_result_t  want;
    word_taken = 1'b0;
    if (!rst_n) begin
      cap_units   = FULL_BANK;
      usage_units = '0;
      evict_order.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: result word with nothing expected: status %0d id %h usage %0d",
                     $realtime, out_status, out_evicted_tile_id, out_usage);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          results_seen++;
          if (out_status !== want.status || out_evicted_tile_id !== want.evicted_id ||
              out_usage !== want.usage) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("%0t: mismatch, expected status %0d id %h usage %0d, got %0d %h %0d",
                       $realtime, want.status, want.evicted_id, want.usage,
                       out_status, out_evicted_tile_id, out_usage);
          end
        end
      end
      if (cfg_we) cap_units = cfg_wdata;
      if (in_valid && !in_stall) begin
        taken = '{in_action, in_tile_id, in_tile_size, in_round};
        want  = bank_occupancy_step(taken);
        expected_results.insert(expected_results.size(), want);
        status_tally[want.status]++;
        requests_taken++;
        pending_requests.delete(0);
        word_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present the head of the pending list at the falling edge.
  // Hold a word that is not yet taken; otherwise advance or idle at random.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid     <= 1'b1;
        in_action    <= pending_requests[0].action;
        in_tile_id   <= pending_requests[0].tile_id;
        in_tile_size <= pending_requests[0].tile_size;
        in_round     <= pending_requests[0].round;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, independent of the sender
  always @(negedge clk) begin : drive_stall
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic act, input logic [ID_W-1:0] id,
                               input logic [SIZE_W-1:0] units, input logic [ROUND_W-1:0] rnd);
    tile_request_t req;
    req = '{act, id, units, rnd};
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Hold until every word is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk); while (pending_requests.size() != 0 || expected_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [SIZE_W-1:0] units);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= units;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations from a small id pool with sizes
  // scaled to the free space, evictions a few rounds ahead of the allocations.
  // About one word in ten is noise with random fields.
  task automatic queue_random_batch(input int count, input int evict_pct);
    tile_request_t req;
    int            pick;
    int            free_units;
    free_units = (cap_units > usage_units) ? int'(cap_units - usage_units) : 0;
    repeat (count) begin
      pick          = $urandom_range(0, 99);
      req.tile_id   = ID_W'($urandom_range(0, 65535));
      req.tile_size = SIZE_W'($urandom_range(0, FULL_BANK));
      if (pick < 10) begin
        req.action = 1'($urandom_range(0, 1));
        // keep noisy allocations at or below the current round so they never pin the head
        req.round  = (req.action == ACT_EVICT) ? ROUND_W'($urandom_range(0, 65535))
                                               : ROUND_W'($urandom_range(0, round_base));
      end else if (pick < 10 + evict_pct) begin
        req.action = ACT_EVICT;
        req.round  = ROUND_W'(round_base + int'($urandom_range(0, 6)));
      end else begin
        req.action  = ACT_ALLOC;
        req.tile_id = ID_W'(pool_base + int'($urandom_range(0, POOL_SPAN - 1)));
        req.round   = ROUND_W'(round_base + int'($urandom_range(0, 8)));
        case ($urandom_range(0, 9))
          0:       req.tile_size = '0;
          1:       req.tile_size = SIZE_W'(free_units);
          2:       req.tile_size = cap_units;
          3:       req.tile_size = (cap_units < FULL_BANK) ? cap_units + 21'd1 : FULL_BANK;
          default: req.tile_size = SIZE_W'($urandom_range(0, free_units / 4 + 1));
        endcase
      end
      pending_requests.insert(pending_requests.size(), req);
      round_base += $urandom_range(0, 2);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          b;
    int          target;
    logic [SIZE_W-1:0] new_cap;

    // Directed words at the reset capacity
    queue_request(ACT_EVICT, 16'hFFFF, FULL_BANK, 16'd0);  // empty queue
    queue_request(ACT_ALLOC, 16'h0000, '0, 16'd0);          // zero-size tile
    queue_request(ACT_ALLOC, 16'hFFFF, FULL_BANK, 16'd5);   // fills the bank exactly
    queue_request(ACT_ALLOC, 16'h0001, 21'd1, 16'd0);       // no space
    queue_request(ACT_ALLOC, 16'h0002, '0, 16'd0);          // zero size fits a full bank
    queue_request(ACT_EVICT, '0, '0, 16'd0);                // head round not below
    queue_request(ACT_EVICT, '0, '0, 16'd1);
    queue_request(ACT_EVICT, '0, '0, 16'd5);
    queue_request(ACT_EVICT, '0, '0, 16'd6);
    queue_request(ACT_EVICT, '0, '0, 16'd6);
    // re-allocation with a smaller round keeps the old one
    queue_request(ACT_ALLOC, 16'h0007, '0, 16'd10);
    queue_request(ACT_ALLOC, 16'h0008, 21'd50, 16'd3);
    queue_request(ACT_ALLOC, 16'h0007, 21'd30, 16'd4);
    queue_request(ACT_EVICT, '0, '0, 16'd4);
    queue_request(ACT_EVICT, '0, '0, 16'd10);
    queue_request(ACT_EVICT, '0, '0, 16'd11);
    // re-allocation with a larger round takes the new one
    queue_request(ACT_ALLOC, 16'h0009, '0, 16'd2);
    queue_request(ACT_ALLOC, 16'h0009, 21'd5, 16'd7);
    queue_request(ACT_EVICT, '0, '0, 16'd7);
    queue_request(ACT_EVICT, '0, '0, 16'd8);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Smallest capacity: too large, exact fit, no space
    write_capacity(21'd1);
    @(posedge clk);
    queue_request(ACT_ALLOC, 16'h0003, 21'd2, 16'd0);
    queue_request(ACT_ALLOC, 16'h0003, 21'd1, 16'd0);
    queue_request(ACT_ALLOC, 16'h0004, 21'd1, 16'd0);
    queue_request(ACT_EVICT, 16'hFFFF, FULL_BANK, 16'hFFFF);
    wait_drained();

    // Random batches; the sender pauses at every boundary until all results are in
    round_base = 24;
    for (b = 0; b < BATCHES; b++) begin
      case (b)
        0:           new_cap = 21'd1;
        1:           new_cap = 21'd48;
        2:           new_cap = 21'd4096;
        3:           new_cap = (usage_units > 1) ? usage_units >> 1 : 21'd1;  // below usage
        4:           new_cap = 21'd65536;
        5:           new_cap = 21'h0AAAAA;
        6:           new_cap = 21'h055555;
        7:           new_cap = FULL_BANK;
        8:           new_cap = 21'd1;
        9:           new_cap = 21'd300;
        BATCHES - 1: new_cap = FULL_BANK;
        default:     new_cap = ($urandom_range(0, 3) == 0)
                               ? SIZE_W'($urandom_range(1, FULL_BANK))
                               : SIZE_W'($urandom_range((usage_units > 0) ? usage_units : 1,
                                                        FULL_BANK));
      endcase
      if (b != 0) write_capacity(new_cap);
      if (b % 2 == 0) pool_base = $urandom_range(0, 65535 - POOL_SPAN + 1);
      // advance rounds in jumps so the upper round bits toggle over the run
      target = (b == BATCHES - 1) ? 'hFE00 : b * 3000 + int'($urandom_range(0, 200));
      if (target > round_base) round_base = target;
      @(posedge clk);
      calm = (b == 6 || b == 7);
      queue_random_batch(BATCH_LEN, $urandom_range(10, 45));
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    errors += expected_results.size();

    $display("Covered %0d requests, %0d results checked, capacity from 1 to full bank.",
             requests_taken, results_seen);
    $display("Outcomes: alloc %0d, no space %0d, too large %0d, evict %0d, none %0d, full %0d",
             status_tally[rbba_pkg::ST_ALLOCATED], status_tally[rbba_pkg::ST_NO_SPACE],
             status_tally[rbba_pkg::ST_TOO_LARGE], status_tally[rbba_pkg::ST_EVICTED],
             status_tally[rbba_pkg::ST_NO_EVICT], status_tally[rbba_pkg::ST_QUEUE_FULL]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #(4_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
